// ----- hdl/ufmc_pkg.sv -----
// Shared types and constants for the union-find maze carver.
// Used by ufmc_div and union_find_maze_carver_top; depends on nothing else.
package ufmc_pkg;

  localparam int MAX_CELLS   = 1024;  // size of the parent, rank and wall stores
  localparam int CELL_W      = 10;  // cell index field width
  localparam int CFG_W       = 11;  // configuration register width
  localparam int RANK_W      = 4;
  localparam int WALL_W      = 4;
  localparam int CNT_W       = 10;  // accepted edge counter width
  localparam int CFG_IDX_W   = 1;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;
  localparam int DIV_STEPS   = CELL_W;
  localparam int DIV_CNT_W   = 4;

  localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

  localparam logic [WALL_W-1:0] WALL_TOP    = 4'd1;
  localparam logic [WALL_W-1:0] WALL_RIGHT  = 4'd2;
  localparam logic [WALL_W-1:0] WALL_BOTTOM = 4'd4;
  localparam logic [WALL_W-1:0] WALL_LEFT   = 4'd8;
  localparam logic [WALL_W-1:0] WALL_ALL    = WALL_TOP | WALL_RIGHT | WALL_BOTTOM | WALL_LEFT;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLUMNS    = 1'b0,
    REG_CELL_COUNT = 1'b1
  } cfg_reg_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIND_RD,
    ST_FIND_CHK,
    ST_COMP_RD,
    ST_COMP_CHK,
    ST_RANK_RD_A,
    ST_RANK_RD_B,
    ST_RANK_CHK,
    ST_DIV_A,
    ST_DIV_B,
    ST_WALL_RD_A,
    ST_WALL_RD_B,
    ST_WALL_CHK,
    ST_WALL_WR_A,
    ST_WALL_WR_B,
    ST_DONE
  } state_t;

  // Result of the shared divider; done pulses for one cycle.
  typedef struct packed {
    logic              done;
    logic [CELL_W-1:0] quot;
    logic [CFG_W-1:0]  rem;
  } div_res_t;

endpackage

// ----- hdl/ufmc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ufmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/ufmc_div.sv -----
// Restoring divider, one quotient bit per cycle, used to split cell indices
// into row and column. Depends on ufmc_pkg.
module ufmc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ufmc_pkg::CELL_W-1:0] dividend,
  input  logic [ufmc_pkg::CFG_W-1:0]  divisor,
  output ufmc_pkg::div_res_t          res
);

  logic                           busy;
  logic [ufmc_pkg::DIV_CNT_W-1:0] cnt;
  logic [ufmc_pkg::CFG_W-1:0]     rem;
  logic [ufmc_pkg::CELL_W-1:0]    quot;
  logic                           done;
  logic [ufmc_pkg::CFG_W:0]       shifted;
  logic [ufmc_pkg::CFG_W:0]       diff;
  logic                           ge;

  // The partial remainder stays below the divisor, so the shifted value
  // fits in one bit more than the divisor.
  assign shifted = {rem, quot[ufmc_pkg::CELL_W-1]};
  assign ge      = shifted >= {1'b0, divisor};
  assign diff    = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= ufmc_pkg::DIV_CNT_W'(ufmc_pkg::DIV_STEPS - 1);
        rem  <= '0;
        quot <= dividend;
      end else if (busy) begin
        rem  <= ge ? diff[ufmc_pkg::CFG_W-1:0] : shifted[ufmc_pkg::CFG_W-1:0];
        quot <= {quot[ufmc_pkg::CELL_W-2:0], ge};
        cnt  <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.done = done;
  assign res.quot = quot;
  assign res.rem  = rem;

endmodule

// ----- hdl/union_find_maze_carver_top.sv -----
// Kruskal maze carver: a disjoint-set forest with union by rank and path
// compression, plus four wall bits per cell. Depends on ufmc_pkg, ufmc_ram, ufmc_div.
//
// After reset the block sweeps all MAX_CELLS entries of its parent, rank and wall
// memories and takes no edge meanwhile; configuration writes are taken at any time.
// It then takes one edge at a time through a sequencer around a single read port
// on the parent memory: each endpoint walks its parent chain to the root, and
// path compression then walks the chain a second time. A merging edge adds the
// rank lookup and union, two runs of the shared one-bit-per-cycle divider for the
// row and column split, and a read and rewrite of both wall entries. A result
// waits in an output register, so the next edge is accepted while it is still
// pending.
module union_find_maze_carver_top (
  input  logic                                 clk,
  input  logic                                 rst,
  // s_tdata: cell_a [9:0], cell_b [19:10], zero fill above
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [ufmc_pkg::IN_TDATA_W-1:0]      s_tdata,
  // m_tdata: merged [0], tree_edges [10:1], complete [11], walls_a [15:12],
  // walls_b [19:16], zero fill above
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [ufmc_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ufmc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ufmc_pkg::CFG_W-1:0]           cfg_data
);

  localparam int ADDR_W = $clog2(ufmc_pkg::MAX_CELLS);
  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(ufmc_pkg::MAX_CELLS - 1);

  ufmc_pkg::state_t state, state_next;

  logic [ufmc_pkg::CFG_W-1:0]  columns, cell_count;
  logic [ufmc_pkg::CFG_W-1:0]  cols_eff, cells_eff, cells_m1;
  logic [ufmc_pkg::CNT_W-1:0]  count;
  logic [ADDR_W-1:0]           clr;
  logic [ufmc_pkg::CELL_W-1:0] cell_a, cell_b;
  logic [ufmc_pkg::CELL_W-1:0] in_a, in_b;
  logic                        side;
  logic [ADDR_W-1:0]           cur, root, root_a;
  logic [ufmc_pkg::RANK_W-1:0] rank_a;
  logic                        merged;
  logic [ufmc_pkg::CELL_W-1:0] quot_a, quot_b;
  logic [ufmc_pkg::CFG_W-1:0]  rem_a, rem_b;
  logic [ufmc_pkg::WALL_W-1:0] walls_a, walls_b;
  logic [ufmc_pkg::WALL_W-1:0] mask_a, mask_b;
  logic                        complete, proceed, a_stored, b_stored, load;

  logic                        par_we;
  logic [ADDR_W-1:0]           par_waddr, par_wdata, par_raddr, par_rdata;
  logic                        rnk_we;
  logic [ADDR_W-1:0]           rnk_waddr, rnk_raddr;
  logic [ufmc_pkg::RANK_W-1:0] rnk_wdata, rnk_rdata;
  logic                        wal_we;
  logic [ADDR_W-1:0]           wal_waddr, wal_raddr;
  logic [ufmc_pkg::WALL_W-1:0] wal_wdata, wal_rdata;

  logic                        div_start;
  logic [ufmc_pkg::CELL_W-1:0] div_dividend;
  ufmc_pkg::div_res_t          div_res;

  // Zero reads as one, values beyond the store size read as the store size.
  always_comb begin
    cols_eff = columns;
    if (columns == '0) begin
      cols_eff = ufmc_pkg::CFG_W'(1);
    end else if (32'(columns) > 32'(ufmc_pkg::MAX_CELLS)) begin
      cols_eff = ufmc_pkg::CFG_W'(ufmc_pkg::MAX_CELLS);
    end
    cells_eff = cell_count;
    if (cell_count == '0) begin
      cells_eff = ufmc_pkg::CFG_W'(1);
    end else if (32'(cell_count) > 32'(ufmc_pkg::MAX_CELLS)) begin
      cells_eff = ufmc_pkg::CFG_W'(ufmc_pkg::MAX_CELLS);
    end
  end

  assign cells_m1 = cells_eff - 1'b1;
  assign complete = {1'b0, count} >= cells_m1;
  assign in_a     = s_tdata[ufmc_pkg::CELL_W-1:0];
  assign in_b     = s_tdata[2*ufmc_pkg::CELL_W-1:ufmc_pkg::CELL_W];
  assign proceed  = !complete && ({1'b0, in_a} < cells_eff) && ({1'b0, in_b} < cells_eff);
  assign a_stored = 32'(cell_a) < 32'(ufmc_pkg::MAX_CELLS);
  assign b_stored = 32'(cell_b) < 32'(ufmc_pkg::MAX_CELLS);
  assign s_tready = state == ufmc_pkg::ST_IDLE;
  assign cfg_ready = 1'b1;
  assign load     = state == ufmc_pkg::ST_DONE && (!m_tvalid || m_tready);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      columns    <= ufmc_pkg::CFG_W'(1);
      cell_count <= ufmc_pkg::CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (ufmc_pkg::cfg_reg_t'(cfg_index))
        ufmc_pkg::REG_COLUMNS:    columns    <= cfg_data;
        ufmc_pkg::REG_CELL_COUNT: cell_count <= cfg_data;
      endcase
    end
  end

  // Wall masks from column difference first, then row difference.
  always_comb begin
    mask_a = ufmc_pkg::WALL_ALL;
    mask_b = ufmc_pkg::WALL_ALL;
    if (12'(rem_b) == 12'(rem_a) + 12'd1) begin
      mask_a = ~ufmc_pkg::WALL_RIGHT;
      mask_b = ~ufmc_pkg::WALL_LEFT;
    end else if (12'(rem_a) == 12'(rem_b) + 12'd1) begin
      mask_a = ~ufmc_pkg::WALL_LEFT;
      mask_b = ~ufmc_pkg::WALL_RIGHT;
    end else if (11'(quot_b) == 11'(quot_a) + 11'd1) begin
      mask_a = ~ufmc_pkg::WALL_BOTTOM;
      mask_b = ~ufmc_pkg::WALL_TOP;
    end else if (11'(quot_a) == 11'(quot_b) + 11'd1) begin
      mask_a = ~ufmc_pkg::WALL_TOP;
      mask_b = ~ufmc_pkg::WALL_BOTTOM;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ufmc_pkg::ST_CLEAR: begin
        if (clr == CLR_LAST) state_next = ufmc_pkg::ST_IDLE;
      end
      ufmc_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = proceed ? ufmc_pkg::ST_FIND_RD : ufmc_pkg::ST_WALL_RD_A;
      end
      ufmc_pkg::ST_FIND_RD:  state_next = ufmc_pkg::ST_FIND_CHK;
      ufmc_pkg::ST_FIND_CHK: begin
        if (par_rdata == cur) state_next = ufmc_pkg::ST_COMP_RD;
      end
      ufmc_pkg::ST_COMP_RD:  state_next = ufmc_pkg::ST_COMP_CHK;
      ufmc_pkg::ST_COMP_CHK: begin
        if (par_rdata == root) begin
          if (!side) begin
            state_next = ufmc_pkg::ST_FIND_RD;
          end else if (root_a != root) begin
            state_next = ufmc_pkg::ST_RANK_RD_A;
          end else begin
            state_next = ufmc_pkg::ST_WALL_RD_A;
          end
        end
      end
      ufmc_pkg::ST_RANK_RD_A: state_next = ufmc_pkg::ST_RANK_RD_B;
      ufmc_pkg::ST_RANK_RD_B: state_next = ufmc_pkg::ST_RANK_CHK;
      ufmc_pkg::ST_RANK_CHK:  state_next = ufmc_pkg::ST_DIV_A;
      ufmc_pkg::ST_DIV_A: begin
        if (div_res.done) state_next = ufmc_pkg::ST_DIV_B;
      end
      ufmc_pkg::ST_DIV_B: begin
        if (div_res.done) state_next = ufmc_pkg::ST_WALL_RD_A;
      end
      ufmc_pkg::ST_WALL_RD_A: state_next = ufmc_pkg::ST_WALL_RD_B;
      ufmc_pkg::ST_WALL_RD_B: state_next = ufmc_pkg::ST_WALL_CHK;
      ufmc_pkg::ST_WALL_CHK:  state_next = merged ? ufmc_pkg::ST_WALL_WR_A : ufmc_pkg::ST_DONE;
      ufmc_pkg::ST_WALL_WR_A: state_next = ufmc_pkg::ST_WALL_WR_B;
      ufmc_pkg::ST_WALL_WR_B: state_next = ufmc_pkg::ST_DONE;
      ufmc_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) state_next = ufmc_pkg::ST_IDLE;
      end
      default: state_next = ufmc_pkg::ST_CLEAR;
    endcase
  end

  // Memory ports and divider control.
  always_comb begin
    par_we       = 1'b0;
    par_waddr    = cur;
    par_wdata    = root;
    par_raddr    = cur;
    rnk_we       = 1'b0;
    rnk_waddr    = root_a;
    rnk_wdata    = rank_a + 1'b1;
    rnk_raddr    = root_a;
    wal_we       = 1'b0;
    wal_waddr    = ADDR_W'(cell_a);
    wal_wdata    = walls_a;
    wal_raddr    = ADDR_W'(cell_a);
    div_start    = 1'b0;
    div_dividend = (state == ufmc_pkg::ST_DIV_A) ? cell_b : cell_a;
    unique case (state)
      ufmc_pkg::ST_CLEAR: begin
        par_we    = 1'b1;
        par_waddr = clr;
        par_wdata = clr;
        rnk_we    = 1'b1;
        rnk_waddr = clr;
        rnk_wdata = '0;
        wal_we    = 1'b1;
        wal_waddr = clr;
        wal_wdata = ufmc_pkg::WALL_ALL;
      end
      ufmc_pkg::ST_FIND_CHK: par_raddr = par_rdata;
      ufmc_pkg::ST_COMP_CHK: begin
        // Point each node on the walked chain straight at the root.
        par_raddr = par_rdata;
        if (par_rdata != root) par_we = 1'b1;
      end
      ufmc_pkg::ST_RANK_RD_B: rnk_raddr = root;
      ufmc_pkg::ST_RANK_CHK: begin
        div_start = 1'b1;
        par_we    = 1'b1;
        if (rank_a < rnk_rdata) begin
          par_waddr = root_a;
          par_wdata = root;
        end else begin
          par_waddr = root;
          par_wdata = root_a;
          if (rank_a == rnk_rdata && rank_a != ufmc_pkg::RANK_MAX) rnk_we = 1'b1;
        end
      end
      ufmc_pkg::ST_DIV_A: div_start = div_res.done;
      ufmc_pkg::ST_WALL_RD_B: wal_raddr = ADDR_W'(cell_b);
      ufmc_pkg::ST_WALL_WR_A: wal_we = 1'b1;
      ufmc_pkg::ST_WALL_WR_B: begin
        wal_we    = 1'b1;
        wal_waddr = ADDR_W'(cell_b);
        wal_wdata = walls_b;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ufmc_pkg::ST_CLEAR;
      clr   <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == ufmc_pkg::ST_CLEAR) clr <= clr + 1'b1;
      if (state == ufmc_pkg::ST_RANK_CHK) count <= count + 1'b1;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ufmc_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          cell_a <= in_a;
          cell_b <= in_b;
          merged <= 1'b0;
          side   <= 1'b0;
          cur    <= ADDR_W'(in_a);
        end
      end
      ufmc_pkg::ST_FIND_CHK: begin
        if (par_rdata == cur) begin
          root <= cur;
          cur  <= side ? ADDR_W'(cell_b) : ADDR_W'(cell_a);
        end else begin
          cur <= par_rdata;
        end
      end
      ufmc_pkg::ST_COMP_CHK: begin
        if (par_rdata != root) begin
          cur <= par_rdata;
        end else if (!side) begin
          side   <= 1'b1;
          root_a <= root;
          cur    <= ADDR_W'(cell_b);
        end
      end
      ufmc_pkg::ST_RANK_RD_B: rank_a <= rnk_rdata;
      ufmc_pkg::ST_RANK_CHK:  merged <= 1'b1;
      ufmc_pkg::ST_DIV_A: begin
        if (div_res.done) begin
          quot_a <= div_res.quot;
          rem_a  <= div_res.rem;
        end
      end
      ufmc_pkg::ST_DIV_B: begin
        if (div_res.done) begin
          quot_b <= div_res.quot;
          rem_b  <= div_res.rem;
        end
      end
      ufmc_pkg::ST_WALL_RD_B: walls_a <= a_stored ? wal_rdata : '0;
      ufmc_pkg::ST_WALL_CHK: begin
        if (merged) begin
          walls_a <= walls_a & mask_a;
          walls_b <= wal_rdata & mask_b;
        end else begin
          walls_b <= b_stored ? wal_rdata : '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register; loads while an earlier result drains.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {4'b0, walls_b, walls_a, complete, count, merged};
    end
  end

  ufmc_ram #(.WIDTH(ADDR_W), .DEPTH(ufmc_pkg::MAX_CELLS)) u_parent (
    .clk   (clk),
    .we    (par_we),
    .waddr (par_waddr),
    .wdata (par_wdata),
    .raddr (par_raddr),
    .rdata (par_rdata)
  );

  ufmc_ram #(.WIDTH(ufmc_pkg::RANK_W), .DEPTH(ufmc_pkg::MAX_CELLS)) u_rank (
    .clk   (clk),
    .we    (rnk_we),
    .waddr (rnk_waddr),
    .wdata (rnk_wdata),
    .raddr (rnk_raddr),
    .rdata (rnk_rdata)
  );

  ufmc_ram #(.WIDTH(ufmc_pkg::WALL_W), .DEPTH(ufmc_pkg::MAX_CELLS)) u_walls (
    .clk   (clk),
    .we    (wal_we),
    .waddr (wal_waddr),
    .wdata (wal_wdata),
    .raddr (wal_raddr),
    .rdata (wal_rdata)
  );

  ufmc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (cols_eff),
    .res      (div_res)
  );

endmodule
